>>> rtl/core/rect_blit_fill_engine_assert.svh
// Assertion macros shared by the blit engine modules.
`ifndef RECT_BLIT_FILL_ENGINE_ASSERT_SVH
`define RECT_BLIT_FILL_ENGINE_ASSERT_SVH

// same-cycle implication
`define RBFE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBFE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rbfe_pkg.sv
// Shared types and constants of the rectangle blit/fill engine.
`default_nettype none
package rbfe_pkg;

  localparam int STORE_DEPTH_DEF = 65536;
  localparam int PIXEL_BITS_DEF  = 8;

  localparam int DIM_W    = 10;
  localparam int ADDR_IN_W = 16;
  localparam int VAL_W    = 8;
  localparam int ACAL_W   = 22;

  localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 10'd320;
  localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 10'd200;
  localparam logic [DIM_W-1:0] DST_WIDTH_RST  = 10'd320;
  localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 10'd200;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ACT_WR_SRC = 3'd0,
    ACT_WR_DST = 3'd1,
    ACT_RD_DST = 3'd2,
    ACT_COPY   = 3'd3,
    ACT_FILL   = 3'd4
  } action_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [ADDR_IN_W-1:0] pixel_address;
    logic [VAL_W-1:0]     pixel_value;
    logic [DIM_W-1:0]     src_x;
    logic [DIM_W-1:0]     src_y;
    logic [DIM_W-1:0]     dst_x;
    logic [DIM_W-1:0]     dst_y;
    logic [DIM_W-1:0]     rect_width;
    logic [DIM_W-1:0]     rect_height;
    logic                 src_whole;
    logic                 dst_whole;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_pixel;
    logic [DIM_W-1:0] clipped_width;
    logic [DIM_W-1:0] clipped_height;
    logic             fault;
  } result_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rect_go;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/rbfe_cfg_regs.sv
// Surface size registers written over the configuration channel.
`default_nettype none
module rbfe_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbfe_pkg::DIM_W-1:0]     cfg_data_i,
  output rbfe_pkg::cfg_t                 cfg_o
);
  import rbfe_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:  cfg_d.src_w = cfg_data_i;
        CFG_SRC_HEIGHT: cfg_d.src_h = cfg_data_i;
        CFG_DST_WIDTH:  cfg_d.dst_w = cfg_data_i;
        CFG_DST_HEIGHT: cfg_d.dst_h = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= SRC_WIDTH_RST;
      cfg_q.src_h <= SRC_HEIGHT_RST;
      cfg_q.dst_w <= DST_WIDTH_RST;
      cfg_q.dst_h <= DST_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rbfe_ctrl.sv
// Sequencer: accepts an item, runs setup and the pixel walk, hands off the result.
`default_nettype none
`include "rect_blit_fill_engine_assert.svh"
module rbfe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  rbfe_pkg::sts_t sts_i,
  output rbfe_pkg::cmd_t cmd_o
);
  import rbfe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   m_valid_q;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    cmd_o.load     = s_valid_i && (state_q == ST_IDLE);
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.step     = (state_q == ST_RUN);
    cmd_o.out_load = (state_q == ST_DONE) && (!m_valid_q || m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= sts_i.rect_go ? ST_RUN : ST_DONE;
        end
        ST_RUN: begin
          if (sts_i.last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `RBFE_ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, s_valid_i && s_ready_o, !s_ready_o, "accept not followed by busy")
  `RBFE_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load, !m_valid_q || m_ready_i, "result overwritten")
  `RBFE_ASSERT_NXT(a_run_ends, clk_i, rst_ni, state_q == ST_RUN && sts_i.last, state_q == ST_DONE, "walk did not end")

endmodule
`default_nettype wire

>>> rtl/core/rbfe_datapath.sv
// Datapath: item registers, clipping, address walker, pixel stores, result register.
`default_nettype none
`include "rect_blit_fill_engine_assert.svh"
module rbfe_datapath #(
  parameter int STORE_DEPTH = rbfe_pkg::STORE_DEPTH_DEF,
  parameter int PIXEL_BITS  = rbfe_pkg::PIXEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbfe_pkg::cfg_t    cfg_i,
  input  rbfe_pkg::item_t   item_i,
  input  rbfe_pkg::cmd_t    cmd_i,
  output rbfe_pkg::sts_t    sts_o,
  output rbfe_pkg::result_t res_o
);
  import rbfe_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [ACAL_W-1:0] DEPTH_A = ACAL_W'(STORE_DEPTH);

  function automatic logic [DIM_W-1:0] clip(input logic [DIM_W-1:0] req,
                                            input logic [DIM_W-1:0] limit,
                                            input logic [DIM_W-1:0] origin);
    logic [DIM_W-1:0] room;
    room = limit - origin;
    if (origin >= limit) begin
      return '0;
    end
    return (req > room) ? room : req;
  endfunction

  // item registers
  item_t                 it_q;
  logic [PIXEL_BITS-1:0] val_q;

  // walker
  logic [DIM_W-1:0]  cw_q, ch_q, col_q, row_q;
  logic [ACAL_W-1:0] da_q, da_row_q, sa_q, sa_row_q;
  logic              copy_q, fault_q;
  logic              wr_pend_q;
  logic [ACAL_W-1:0] wr_addr_q;

  // stores
  logic [PIXEL_BITS-1:0] src_mem [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] dst_mem [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] src_rd_q, dst_rd_q;

  result_t res_q;

  // setup logic
  logic                   is_copy, is_rect, is_pix;
  logic [DIM_W-1:0]       edx, edy, esx, esy, erw, erh, cw_set, ch_set;
  logic [2*DIM_W-1:0]     dprod, sprod;
  logic [ACAL_W-1:0]      da_base, sa_base, pix_a;
  logic                   pix_ok, da_ok, sa_ok, row_end;

  always_comb begin
    is_copy = (it_q.action == ACT_COPY);
    is_rect = is_copy || (it_q.action == ACT_FILL);
    is_pix  = (it_q.action == ACT_WR_SRC) || (it_q.action == ACT_WR_DST) ||
              (it_q.action == ACT_RD_DST);
    edx = it_q.dst_whole ? '0 : it_q.dst_x;
    edy = it_q.dst_whole ? '0 : it_q.dst_y;
    esx = it_q.src_whole ? '0 : it_q.src_x;
    esy = it_q.src_whole ? '0 : it_q.src_y;
    if (is_copy) begin
      erw = it_q.src_whole ? cfg_i.src_w : it_q.rect_width;
      erh = it_q.src_whole ? cfg_i.src_h : it_q.rect_height;
    end else begin
      erw = it_q.dst_whole ? cfg_i.dst_w : it_q.rect_width;
      erh = it_q.dst_whole ? cfg_i.dst_h : it_q.rect_height;
    end
    cw_set  = is_rect ? clip(erw, cfg_i.dst_w, edx) : '0;
    ch_set  = is_rect ? clip(erh, cfg_i.dst_h, edy) : '0;
    dprod   = edy * cfg_i.dst_w;
    sprod   = esy * cfg_i.src_w;
    da_base = ACAL_W'(edx) + ACAL_W'(dprod);
    sa_base = ACAL_W'(esx) + ACAL_W'(sprod);
    pix_a   = ACAL_W'(it_q.pixel_address);
    pix_ok  = pix_a < DEPTH_A;
    da_ok   = da_q < DEPTH_A;
    sa_ok   = sa_q < DEPTH_A;
    row_end = (col_q == cw_q - 10'd1);
  end

  assign sts_o.rect_go = is_rect && (cw_set != '0) && (ch_set != '0);
  assign sts_o.last    = row_end && (row_q == ch_q - 10'd1);

  // store port controls
  logic                  src_we, src_re, dst_we, dst_re;
  logic [ACAL_W-1:0]     dst_wa;
  logic [PIXEL_BITS-1:0] dst_wd;

  always_comb begin
    src_we = cmd_i.setup && pix_ok && (it_q.action == ACT_WR_SRC);
    src_re = cmd_i.step && copy_q && sa_ok;
    dst_re = cmd_i.setup && pix_ok && (it_q.action == ACT_RD_DST);
    dst_we = wr_pend_q || (cmd_i.step && !copy_q && da_ok) ||
             (cmd_i.setup && pix_ok && (it_q.action == ACT_WR_DST));
    if (wr_pend_q) begin
      dst_wa = wr_addr_q;
      dst_wd = src_rd_q;
    end else begin
      dst_wa = cmd_i.setup ? pix_a : da_q;
      dst_wd = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[pix_a[AW-1:0]] <= val_q;
    end
    if (src_re) begin
      src_rd_q <= src_mem[sa_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dst_we) begin
      dst_mem[dst_wa[AW-1:0]] <= dst_wd;
    end
    if (dst_re) begin
      dst_rd_q <= dst_mem[pix_a[AW-1:0]];
    end
  end

  // payload, walker and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q  <= item_i;
      val_q <= PIXEL_BITS'(item_i.pixel_value);
    end
    if (cmd_i.setup) begin
      cw_q     <= cw_set;
      ch_q     <= ch_set;
      col_q    <= '0;
      row_q    <= '0;
      da_q     <= da_base;
      da_row_q <= da_base;
      sa_q     <= sa_base;
      sa_row_q <= sa_base;
      copy_q   <= is_copy;
    end else if (cmd_i.step) begin
      wr_addr_q <= da_q;
      if (row_end) begin
        col_q    <= '0;
        row_q    <= row_q + 10'd1;
        da_row_q <= da_row_q + ACAL_W'(cfg_i.dst_w);
        da_q     <= da_row_q + ACAL_W'(cfg_i.dst_w);
        sa_row_q <= sa_row_q + ACAL_W'(cfg_i.src_w);
        sa_q     <= sa_row_q + ACAL_W'(cfg_i.src_w);
      end else begin
        col_q <= col_q + 10'd1;
        da_q  <= da_q + 22'd1;
        sa_q  <= sa_q + 22'd1;
      end
    end
    if (cmd_i.out_load) begin
      res_q.read_pixel     <= ((it_q.action == ACT_RD_DST) && !fault_q) ?
                              VAL_W'(dst_rd_q) : '0;
      res_q.clipped_width  <= cw_q;
      res_q.clipped_height <= ch_q;
      res_q.fault          <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q   <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.step && copy_q && sa_ok && da_ok;
      if (cmd_i.setup) begin
        fault_q <= is_pix && !pix_ok;
      end else if (cmd_i.step) begin
        fault_q <= fault_q || !da_ok || (copy_q && !sa_ok);
      end
    end
  end

  assign res_o = res_q;

  `RBFE_ASSERT_IMP(a_dst_wr_range, clk_i, rst_ni, dst_we, dst_wa < DEPTH_A, "dest write out of range")
  `RBFE_ASSERT_IMP(a_pend_after_step, clk_i, rst_ni, wr_pend_q, $past(cmd_i.step), "copy write without step")
  `RBFE_ASSERT_NXT(a_fault_sticky, clk_i, rst_ni, cmd_i.step && fault_q, fault_q, "fault dropped in walk")

endmodule
`default_nettype wire

>>> rtl/core/rect_blit_fill_engine.sv
// Top level of the rectangle blit/fill engine.
// Each input item is one action on two 8-bit indexed pixel stores (source and destination):
// a pixel write or read passes from accept through the setup and done states to the result
// register; a copy or fill also runs the address walker between them, which visits one clipped
// pixel per cycle through the single write port of the destination store. The next item is
// accepted in the cycle after the result is loaded. A new item is accepted once the previous
// one has finished, even while its result still waits on the output register. The stores
// have no reset: reading a pixel that was never written returns an undefined value.
`default_nettype none
module rect_blit_fill_engine #(
  parameter int STORE_DEPTH = rbfe_pkg::STORE_DEPTH_DEF,
  parameter int PIXEL_BITS  = rbfe_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pixel_address, pixel_value, src_x, src_y, dst_x, dst_y, rect_width, rect_height, pad
  input  logic [87:0]                    s_axis_tdata,
  // action, src_whole, dst_whole
  input  logic [4:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // read_pixel, clipped_width, clipped_height, pad
  output logic [31:0]                    m_axis_tdata,
  // fault
  output logic                           m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbfe_pkg::DIM_W-1:0]     cfg_data_i
);
  import rbfe_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  cmd_t    cmd;
  sts_t    sts;

  always_comb begin
    item.action        = s_axis_tuser[2:0];
    item.src_whole     = s_axis_tuser[3];
    item.dst_whole     = s_axis_tuser[4];
    item.pixel_address = s_axis_tdata[15:0];
    item.pixel_value   = s_axis_tdata[23:16];
    item.src_x         = s_axis_tdata[33:24];
    item.src_y         = s_axis_tdata[43:34];
    item.dst_x         = s_axis_tdata[53:44];
    item.dst_y         = s_axis_tdata[63:54];
    item.rect_width    = s_axis_tdata[73:64];
    item.rect_height   = s_axis_tdata[83:74];
  end

  assign m_axis_tdata = {4'd0, res.clipped_height, res.clipped_width, res.read_pixel};
  assign m_axis_tuser = res.fault;

  rbfe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rbfe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rbfe_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

endmodule
`default_nettype wire

>>> tb/rect_blit_fill_engine_tb.sv
// Self-checking testbench for the rectangle blit/fill engine: directed table, then random items.
module rect_blit_fill_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbfe_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int WALK_BUDGET = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 19;
  localparam int MAX_SRC_PREFILL = 16;
  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_LAST = 3'd7;

  localparam cfg_t PHASE_GEOM [4] = '{
    '{10'd16, 10'd16, 10'd64, 10'd64},
    '{10'd1023, 10'd3, 10'd1023, 10'd70},
    '{10'd320, 10'd200, 10'd320, 10'd200},
    '{10'd5, 10'd1023, 10'd1, 10'd1023}
  };
  localparam int PHASE_TX_IDLE [4] = '{0, 78, 0, 18};
  localparam int PHASE_RX_STALL [4] = '{0, 0, 78, 18};
  localparam int PRESSURE_PHASE = 2;

  typedef struct {
    bit      is_geom;
    cfg_t    geom;
    item_t   it;
    bit      known;
    result_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [4:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0] cfg_data_i;

  // shadow copy of the engine state
  bit [7:0] src_pix [DEPTH];
  bit [7:0] dst_pix [DEPTH];
  bit src_set [DEPTH];
  cfg_t geom_now;

  result_t blit_expected_q [$];
  plan_row_t plan [$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int sent_items = 0;
  int phase_end = 0;
  bit hold_go = 1'b0;
  logic hold_off = 1'b0;
  result_t got, want;

  always #4 clk_i = ~clk_i;

  rect_blit_fill_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic int clip_len(input int req, input int lim, input int org);
    if (org >= lim) return 0;
    return (req > lim - org) ? lim - org : req;
  endfunction

  function automatic void rect_geom(input item_t it, output int sx, output int sy,
                                    output int dx, output int dy,
                                    output int cw, output int ch);
    int rw, rh;
    sx = it.src_x;
    sy = it.src_y;
    dx = it.dst_x;
    dy = it.dst_y;
    rw = it.rect_width;
    rh = it.rect_height;
    if (it.dst_whole) begin
      dx = 0;
      dy = 0;
    end
    if (it.action == ACT_COPY) begin
      if (it.src_whole) begin
        sx = 0;
        sy = 0;
        rw = geom_now.src_w;
        rh = geom_now.src_h;
      end
    end else if (it.dst_whole) begin
      rw = geom_now.dst_w;
      rh = geom_now.dst_h;
    end
    cw = clip_len(rw, geom_now.dst_w, dx);
    ch = clip_len(rh, geom_now.dst_h, dy);
  endfunction

  function automatic result_t blit_predict(input item_t it);
    result_t r;
    int sx, sy, dx, dy, cw, ch, da, sa;
    bit [7:0] pix;
    r = '0;
    case (it.action)
      ACT_WR_SRC: begin
        src_pix[it.pixel_address] = it.pixel_value;
        src_set[it.pixel_address] = 1'b1;
      end
      ACT_WR_DST: dst_pix[it.pixel_address] = it.pixel_value;
      ACT_RD_DST: r.read_pixel = dst_pix[it.pixel_address];
      ACT_COPY, ACT_FILL: begin
        rect_geom(it, sx, sy, dx, dy, cw, ch);
        r.clipped_width = cw[9:0];
        r.clipped_height = ch[9:0];
        for (int i = 0; i < cw; i++) begin
          for (int j = 0; j < ch; j++) begin
            da = (dx + i) + (dy + j) * int'(geom_now.dst_w);
            pix = it.pixel_value;
            if (it.action == ACT_COPY) begin
              sa = (sx + i) + (sy + j) * int'(geom_now.src_w);
              if (sa >= DEPTH) begin
                r.fault = 1'b1;
                continue;
              end
              pix = src_pix[sa];
            end
            if (da >= DEPTH) begin
              r.fault = 1'b1;
              continue;
            end
            dst_pix[da] = pix;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t act_row(input logic [2:0] a, input logic [15:0] ad,
                                        input logic [7:0] v, input logic [9:0] sx, sy,
                                        input logic [9:0] dx, dy, rw, rh,
                                        input logic sw, dw);
    plan_row_t r;
    r.is_geom = 1'b0;
    r.geom = '0;
    r.it = '{a, ad, v, sx, sy, dx, dy, rw, rh, sw, dw};
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t known_res(input plan_row_t r, input logic [7:0] rp,
                                          input logic [9:0] cw, ch, input logic f);
    r.known = 1'b1;
    r.want = '{rp, cw, ch, f};
    return r;
  endfunction

  function automatic plan_row_t geom_row(input cfg_t g);
    plan_row_t r;
    r = act_row(ACT_WR_SRC, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    r.is_geom = 1'b1;
    r.geom = g;
    return r;
  endfunction

  task automatic issue(input item_t it, input bit known, input result_t w);
    result_t pred;
    int gap;
    pred = blit_predict(it);
    blit_expected_q.push_back(known ? w : pred);
    sent_items++;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.rect_height, it.rect_width, it.dst_y, it.dst_x,
                     it.src_y, it.src_x, it.pixel_value, it.pixel_address};
    s_axis_tuser <= {it.dst_whole, it.src_whole, it.action};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // registers change only with the engine drained
  task automatic load_geometry(input cfg_t g);
    s_axis_tvalid <= 1'b0;
    while (blit_expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    put_reg(CFG_SRC_WIDTH, g.src_w);
    put_reg(CFG_SRC_HEIGHT, g.src_h);
    put_reg(CFG_DST_WIDTH, g.dst_w);
    put_reg(CFG_DST_HEIGHT, g.dst_h);
    cfg_valid_i <= 1'b0;
    geom_now = g;
  endtask

  function automatic logic [9:0] near_edge(input logic [9:0] lim);
    int org;
    org = int'(lim) - int'($urandom_range(0, 12));
    return (org < 0) ? 10'd0 : org[9:0];
  endfunction

  task automatic random_action();
    item_t it, wr;
    int r, sx, sy, dx, dy, cw, ch, sa;
    int miss [$];
    it = '{3'($urandom), 16'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
           10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
           1'($urandom), 1'($urandom)};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it.action = ACT_WR_SRC;
      if ($urandom_range(0, 1)) it.pixel_address = 16'($urandom_range(0, 2047));
    end else if (r < 30) begin
      it.action = ACT_WR_DST;
    end else if (r < 45) begin
      it.action = ACT_RD_DST;
    end else if (r < 92) begin
      it.action = (r < 70) ? ACT_COPY : ACT_FILL;
      it.src_whole = ($urandom_range(0, 4) == 0);
      it.dst_whole = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        it.rect_width = 10'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) it.dst_x = 10'($urandom_range(0, geom_now.dst_w));
      end else begin
        it.dst_x = near_edge(geom_now.dst_w);
      end
      if ($urandom_range(0, 1)) begin
        it.rect_height = 10'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) it.dst_y = 10'($urandom_range(0, geom_now.dst_h));
      end else begin
        it.dst_y = near_edge(geom_now.dst_h);
      end
      if ($urandom_range(0, 3) != 0) begin
        it.src_x = 10'($urandom_range(0, 7));
        it.src_y = 10'($urandom_range(0, 7));
      end
      rect_geom(it, sx, sy, dx, dy, cw, ch);
      if (cw * ch > WALK_BUDGET) begin
        it.src_whole = 1'b0;
        it.dst_whole = 1'b0;
      end
      if (it.action == ACT_COPY) begin
        rect_geom(it, sx, sy, dx, dy, cw, ch);
        for (int i = 0; i < cw; i++) begin
          for (int j = 0; j < ch; j++) begin
            sa = (sx + i) + (sy + j) * int'(geom_now.src_w);
            if (sa < DEPTH && !src_set[sa]) miss.push_back(sa);
          end
        end
        // source pixels must be defined before a copy reads them
        if (miss.size() > MAX_SRC_PREFILL) begin
          it.action = ACT_FILL;
          it.dst_whole = 1'b0;
        end else begin
          foreach (miss[k]) begin
            wr = '{ACT_WR_SRC, miss[k][15:0], 8'($urandom), 10'($urandom), 10'($urandom),
                   10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                   1'($urandom), 1'($urandom)};
            issue(wr, 1'b0, '0);
          end
        end
      end
    end else begin
      it.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
    end
    issue(it, 1'b0, '0);
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[27:18], m_axis_tuser};
      if (blit_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = blit_expected_q.pop_front();
        if (got.read_pixel !== want.read_pixel || got.clipped_width !== want.clipped_width ||
            got.clipped_height !== want.clipped_height || got.fault !== want.fault) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pix %0h w %0d h %0d fault %0b / got pix %0h w %0d h %0d fault %0b",
                     want.read_pixel, want.clipped_width, want.clipped_height, want.fault,
                     got.read_pixel, got.clipped_width, got.clipped_height, got.fault);
        end
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long receiver hold-off so the input side backs up
  initial begin
    @(posedge hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("rect_blit_fill_engine_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SRC_WIDTH;
    cfg_data_i <= '0;
    geom_now = '{SRC_WIDTH_RST, SRC_HEIGHT_RST, DST_WIDTH_RST, DST_HEIGHT_RST};

    plan.push_back(known_res(act_row(ACT_WR_DST, 16'h0000, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_FILL, 16'hffff, 8'h5a, 10'h3ff, 10'h3ff, 10'h3ff,
                                     10'h3ff, 10'h3ff, 10'h3ff, 1, 1), 0, 320, 200, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'h5a, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'd63999, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'h5a, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_WR_SRC, 16'h0000, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_WR_SRC, 16'hffff, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_WR_DST, 16'hffff, 8'h81, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'h81, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_RSVD_FIRST, 16'hffff, 8'hff, 10'h3ff, 10'h3ff,
                                     10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1), 0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_RSVD_MID, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_RSVD_LAST, 16'hffff, 8'hff, 10'h3ff, 10'h3ff,
                                     10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1), 0, 0, 0, 0));
    // origin right of the destination edge: width clips to zero, nothing drawn
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h11, 0, 0, 10'd1023, 10'd0, 10'd1023,
                                     10'd5, 0, 0), 0, 0, 5, 0));
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h22, 0, 0, 10'd300, 10'd190, 10'd1023,
                                     10'd1023, 0, 0), 0, 20, 10, 0));
    plan.push_back(known_res(act_row(ACT_COPY, 0, 0, 0, 0, 10'd5, 10'd5, 10'd1, 10'd1, 0, 0),
                             0, 1, 1, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'd1605, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'hff, 0, 0, 0));
    // every source address beyond the store
    plan.push_back(known_res(act_row(ACT_COPY, 0, 0, 10'd1023, 10'd1023, 10'd10, 10'd10,
                                     10'd2, 10'd2, 0, 0), 0, 2, 2, 1));
    plan.push_back(geom_row('{10'd1023, 10'd200, 10'd256, 10'd256}));
    // 256x256 covers the whole destination store, so every later read is defined
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h33, 0, 0, 0, 0, 0, 0, 0, 1),
                             0, 256, 256, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'h33, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h44, 0, 0, 10'd250, 10'd250, 10'd1023,
                                     10'd1023, 0, 0), 0, 6, 6, 0));
    plan.push_back(geom_row('{10'd1023, 10'd200, 10'd1023, 10'd1023}));
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h55, 0, 0, 10'd0, 10'd64, 10'd4, 10'd4,
                                     0, 0), 0, 4, 4, 1));
    plan.push_back(known_res(act_row(ACT_COPY, 0, 0, 10'd0, 10'd70, 0, 0, 10'd3, 10'd3, 0, 0),
                             0, 3, 3, 1));
    plan.push_back(geom_row('{10'd1, 10'd1, 10'd1023, 10'd1}));
    plan.push_back(known_res(act_row(ACT_COPY, 16'hffff, 8'hff, 10'h3ff, 10'h3ff, 10'h3ff,
                                     10'h3ff, 10'h3ff, 10'h3ff, 1, 1), 0, 1, 1, 0));
    plan.push_back(known_res(act_row(ACT_RD_DST, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8'hff, 0, 0, 0));
    plan.push_back(known_res(act_row(ACT_FILL, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1),
                             0, 1023, 1, 0));
    plan.push_back(act_row(ACT_RD_DST, 16'd1022, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_geom) load_geometry(plan[k].geom);
      else issue(plan[k].it, plan[k].known, plan[k].want);
    end

    for (int p = 0; p < 4; p++) begin
      load_geometry(PHASE_GEOM[p]);
      tx_idle_pct = PHASE_TX_IDLE[p];
      rx_stall_pct = PHASE_RX_STALL[p];
      if (p == PRESSURE_PHASE) hold_go = 1'b1;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) random_action();
    end

    s_axis_tvalid <= 1'b0;
    while (blit_expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && blit_expected_q.size() == 0) begin
      $display("rect_blit_fill_engine_tb OK");
    end else begin
      $display("rect_blit_fill_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
